FILE: rtl/core/pwtd_pkg.sv
// ----------------------------------------------------------------------------
// pwtd_pkg
// Shared types and constants for the partition-with-target-difference block.
// ----------------------------------------------------------------------------
package pwtd_pkg;

  // width of the target difference register
  localparam int unsigned TDW = 12;
  // width of a reachability memory word
  localparam int unsigned MWORD = 64;
  // width of the element ports
  localparam int unsigned EPW = 8;

  typedef struct packed {
    logic load;       // take the offered element
    logic clr_w;      // restart the word sweep
    logic init_wr;    // write one word of the empty-suffix row
    logic bld_begin;  // start building rows from the last element down
    logic el_rd;      // read the element store at the current index
    logic swp;        // issue reads for one word of the shift-or sweep
    logic row_done;   // one suffix row finished
    logic chk_begin;  // prepare the walk over the list
    logic qry;        // issue the two reachability probes
    logic qry_elem;   // probe includes the current element
    logic emit_imp;   // send the impossible result
    logic emit_el;    // send one element assignment
    logic finish;     // close the list
  } ctrl_cmd_t;

  typedef struct packed {
    logic w_last;
    logic idx_zero;
    logic idx_last;
    logic reach;
  } dp_status_t;

endpackage

FILE: rtl/core/pwtd_dp.sv
// ----------------------------------------------------------------------------
// pwtd_dp
// Datapath: element store, suffix reachability memory with its shift-or
// sweep, probe arithmetic, running difference and result register.
// ----------------------------------------------------------------------------
module pwtd_dp #(
  parameter int unsigned MAX_ELEMS   = 16,
  parameter int unsigned VALUE_WIDTH = 8
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  pwtd_pkg::ctrl_cmd_t            cmd_i,
  output pwtd_pkg::dp_status_t           status_o,
  input  logic [pwtd_pkg::EPW-1:0]       element_value_i,
  input  logic                           cfg_we_i,
  input  logic [pwtd_pkg::TDW-1:0]       cfg_wdata_i,
  output logic                           result_valid_o,
  output logic                           possible_o,
  output logic [pwtd_pkg::EPW-1:0]       element_out_o,
  output logic                           side_o,
  output logic                           last_result_o
);

  localparam int unsigned VMASK     = (1 << VALUE_WIDTH) - 1;
  localparam int unsigned MAX_SUM   = MAX_ELEMS * VMASK;
  localparam int unsigned SET_WORDS = (MAX_SUM + 64) / 64;
  localparam int unsigned MEM_DEPTH = (MAX_ELEMS + 1) * SET_WORDS;
  localparam int unsigned MAW       = $clog2(MEM_DEPTH);
  localparam int unsigned SUMW      = $clog2(MAX_SUM + 1);
  localparam int unsigned CW        = $clog2(MAX_ELEMS + 1);
  localparam int unsigned IW        = (MAX_ELEMS > 1) ? $clog2(MAX_ELEMS) : 1;
  localparam int unsigned WW        = (SET_WORDS > 1) ? $clog2(SET_WORDS) : 1;
  localparam int unsigned EW        = (VALUE_WIDTH < pwtd_pkg::EPW) ? VALUE_WIDTH
                                                                    : pwtd_pkg::EPW;
  localparam int unsigned DW        = SUMW + 2;
  localparam int unsigned CANW      = ((SUMW > pwtd_pkg::TDW) ? SUMW : pwtd_pkg::TDW) + 3;
  localparam int unsigned MW        = pwtd_pkg::MWORD;

  logic [MW-1:0] reach_mem [MEM_DEPTH];
  logic [EW-1:0] elem_mem  [MAX_ELEMS];

  logic [pwtd_pkg::TDW-1:0] k_q;
  logic [CW-1:0]            count_q;
  logic [CW-1:0]            idx_q;
  logic [WW-1:0]            w_q;
  logic                     wr_valid_q;
  logic [WW-1:0]            wr_w_q;
  logic                     b_ok_q;
  logic [MW-1:0]            carry_q;
  logic [SUMW-1:0]          total_q;
  logic [SUMW-1:0]          rem_q;
  logic signed [DW-1:0]     d_q;
  logic                     res_valid_q;

  logic [EW-1:0]            elem_q;
  logic [MW-1:0]            rd_a_q, rd_b_q;
  logic                     ok0_q, ok1_q;
  logic [5:0]               bit0_q, bit1_q;
  logic                     possible_q, side_q, last_q;
  logic [pwtd_pkg::EPW-1:0] elem_out_q;

  // sweep addressing
  logic [15:0]     e16;
  logic [9:0]      ws;
  logic [5:0]      bs;
  logic [CW-1:0]   src_row;
  logic            b_ok_d;
  logic [31:0]     src_base, dst_base, b_word;
  logic [MW-1:0]   b_eff;
  logic [2*MW-1:0] shl;
  logic [MW-1:0]   sweep_wdata;

  // probe arithmetic
  logic [SUMW-1:0]        e_p, rem_p;
  logic [CW-1:0]          p_row;
  logic signed [CANW-1:0] k_s, dd_s, rem_s, c0, c1;
  logic [CANW-2:0]        h0, h1, a0, a1;
  logic                   ok0_d, ok1_d;
  logic [31:0]            p_base;

  logic [MAW-1:0] ra, rb, wa;
  logic [MW-1:0]  wdata;
  logic           we;
  logic           reach;
  logic signed [DW-1:0] e_d;

  always_comb begin
    e16      = 16'(elem_q);
    ws       = e16[15:6];
    bs       = e16[5:0];
    src_row  = idx_q + CW'(1);
    src_base = 32'(src_row) * 32'(SET_WORDS);
    dst_base = 32'(idx_q) * 32'(SET_WORDS);
    b_ok_d   = 32'(w_q) >= 32'(ws);
    b_word   = b_ok_d ? (32'(w_q) - 32'(ws)) : 32'd0;
    b_eff    = b_ok_q ? rd_b_q : '0;
    // upper half of {cur, prev} << bs is src[w-ws] << bs | src[w-ws-1] >> (64-bs)
    shl         = {b_eff, carry_q} << bs;
    sweep_wdata = rd_a_q | shl[2*MW-1:MW];
  end

  always_comb begin
    e_p   = cmd_i.qry_elem ? SUMW'(elem_q) : '0;
    rem_p = rem_q - e_p;
    p_row = cmd_i.qry_elem ? (idx_q + CW'(1)) : idx_q;
    k_s   = $signed({{(CANW - pwtd_pkg::TDW){1'b0}}, k_q});
    dd_s  = CANW'(d_q) + $signed({{(CANW - SUMW){1'b0}}, e_p});
    rem_s = $signed({{(CANW - SUMW){1'b0}}, rem_p});
    c0    = k_s - dd_s + rem_s;
    c1    = -k_s - dd_s + rem_s;
    h0    = c0[CANW-1:1];
    h1    = c1[CANW-1:1];
    ok0_d = !c0[CANW-1] && !c0[0] && (CANW'(h0) <= CANW'(rem_p));
    ok1_d = !c1[CANW-1] && !c1[0] && (CANW'(h1) <= CANW'(rem_p));
    a0    = ok0_d ? h0 : '0;
    a1    = ok1_d ? h1 : '0;
    p_base = 32'(p_row) * 32'(SET_WORDS);
  end

  always_comb begin
    if (cmd_i.qry) begin
      ra = MAW'(p_base + 32'(a0 >> 6));
      rb = MAW'(p_base + 32'(a1 >> 6));
    end else begin
      ra = MAW'(src_base + 32'(w_q));
      rb = MAW'(src_base + b_word);
    end
    if (cmd_i.init_wr) begin
      wa    = MAW'(32'(count_q) * 32'(SET_WORDS) + 32'(w_q));
      wdata = (w_q == '0) ? MW'(1) : '0;
      we    = 1'b1;
    end else begin
      wa    = MAW'(dst_base + 32'(wr_w_q));
      wdata = sweep_wdata;
      we    = wr_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      reach_mem[wa] <= wdata;
    end
    rd_a_q <= reach_mem[ra];
    rd_b_q <= reach_mem[rb];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load && (count_q < CW'(MAX_ELEMS))) begin
      elem_mem[count_q[IW-1:0]] <= element_value_i[EW-1:0];
    end
    if (cmd_i.el_rd) begin
      elem_q <= elem_mem[idx_q[IW-1:0]];
    end
  end

  assign reach = (ok0_q && rd_a_q[bit0_q]) || (ok1_q && rd_b_q[bit1_q]);
  assign e_d   = $signed({{(DW - EW){1'b0}}, elem_q});

  always_ff @(posedge clk_i) begin
    wr_w_q <= w_q;
    b_ok_q <= b_ok_d;
    if (cmd_i.qry) begin
      ok0_q  <= ok0_d;
      ok1_q  <= ok1_d;
      bit0_q <= a0[5:0];
      bit1_q <= a1[5:0];
    end
    if (cmd_i.emit_imp) begin
      possible_q <= 1'b0;
      elem_out_q <= '0;
      side_q     <= 1'b0;
      last_q     <= 1'b1;
    end else if (cmd_i.emit_el) begin
      possible_q <= 1'b1;
      elem_out_q <= pwtd_pkg::EPW'(elem_q);
      side_q     <= !reach;
      last_q     <= status_o.idx_last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_q         <= '0;
      count_q     <= '0;
      idx_q       <= '0;
      w_q         <= '0;
      wr_valid_q  <= 1'b0;
      carry_q     <= '0;
      total_q     <= '0;
      rem_q       <= '0;
      d_q         <= '0;
      res_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        k_q <= cfg_wdata_i;
      end
      if (cmd_i.load && (count_q < CW'(MAX_ELEMS))) begin
        count_q <= count_q + CW'(1);
      end
      if (cmd_i.finish) begin
        count_q <= '0;
      end
      wr_valid_q <= cmd_i.swp;
      if (cmd_i.clr_w) begin
        w_q     <= '0;
        carry_q <= '0;
      end else begin
        if (cmd_i.swp || cmd_i.init_wr) begin
          w_q <= w_q + WW'(1);
        end
        if (wr_valid_q) begin
          carry_q <= b_eff;
        end
      end
      if (cmd_i.bld_begin) begin
        idx_q   <= count_q - CW'(1);
        total_q <= '0;
      end
      if (cmd_i.row_done) begin
        total_q <= total_q + SUMW'(elem_q);
        if (idx_q != '0) begin
          idx_q <= idx_q - CW'(1);
        end
      end
      if (cmd_i.chk_begin) begin
        rem_q <= total_q + SUMW'(elem_q);
        d_q   <= '0;
        idx_q <= '0;
      end
      if (cmd_i.emit_el) begin
        rem_q <= rem_q - SUMW'(elem_q);
        d_q   <= reach ? (d_q + e_d) : (d_q - e_d);
        idx_q <= idx_q + CW'(1);
      end
      res_valid_q <= cmd_i.emit_imp || cmd_i.emit_el;
    end
  end

  always_comb begin
    status_o.w_last   = (w_q == WW'(SET_WORDS - 1));
    status_o.idx_zero = (idx_q == '0);
    status_o.idx_last = (idx_q == (count_q - CW'(1)));
    status_o.reach    = reach;
  end

  assign result_valid_o = res_valid_q;
  assign possible_o     = possible_q;
  assign element_out_o  = elem_out_q;
  assign side_o         = side_q;
  assign last_result_o  = last_q;

endmodule

FILE: rtl/core/pwtd_ctrl.sv
// ----------------------------------------------------------------------------
// pwtd_ctrl
// Sequencer: list load, suffix row build, feasibility check and answer walk.
// ----------------------------------------------------------------------------
module pwtd_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic                  last_element_i,
  output logic                  busy_o,
  input  pwtd_pkg::dp_status_t  status_i,
  output pwtd_pkg::ctrl_cmd_t   cmd_o
);

  typedef enum logic [9:0] {
    S_IDLE = 10'b00_0000_0001,
    S_INIT = 10'b00_0000_0010,
    S_BRD  = 10'b00_0000_0100,
    S_BSWP = 10'b00_0000_1000,
    S_BDRN = 10'b00_0001_0000,
    S_CQRY = 10'b00_0010_0000,
    S_CEV  = 10'b00_0100_0000,
    S_ARD  = 10'b00_1000_0000,
    S_AQRY = 10'b01_0000_0000,
    S_AEV  = 10'b10_0000_0000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          cmd_o.load = 1'b1;
          if (last_element_i) begin
            cmd_o.clr_w = 1'b1;
            state_d     = S_INIT;
          end
        end
      end
      S_INIT: begin
        cmd_o.init_wr = 1'b1;
        if (status_i.w_last) begin
          cmd_o.clr_w     = 1'b1;
          cmd_o.bld_begin = 1'b1;
          state_d         = S_BRD;
        end
      end
      S_BRD: begin
        cmd_o.el_rd = 1'b1;
        state_d     = S_BSWP;
      end
      S_BSWP: begin
        cmd_o.swp = 1'b1;
        if (status_i.w_last) begin
          state_d = S_BDRN;
        end
      end
      S_BDRN: begin
        // last word of the row is written here
        cmd_o.row_done = 1'b1;
        cmd_o.clr_w    = 1'b1;
        if (status_i.idx_zero) begin
          cmd_o.chk_begin = 1'b1;
          state_d         = S_CQRY;
        end else begin
          state_d = S_BRD;
        end
      end
      S_CQRY: begin
        cmd_o.qry = 1'b1;
        state_d   = S_CEV;
      end
      S_CEV: begin
        if (status_i.reach) begin
          state_d = S_ARD;
        end else begin
          cmd_o.emit_imp = 1'b1;
          cmd_o.finish   = 1'b1;
          state_d        = S_IDLE;
        end
      end
      S_ARD: begin
        cmd_o.el_rd = 1'b1;
        state_d     = S_AQRY;
      end
      S_AQRY: begin
        cmd_o.qry      = 1'b1;
        cmd_o.qry_elem = 1'b1;
        state_d        = S_AEV;
      end
      S_AEV: begin
        cmd_o.emit_el = 1'b1;
        if (status_i.idx_last) begin
          cmd_o.finish = 1'b1;
          state_d      = S_IDLE;
        end else begin
          state_d = S_ARD;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o = (state_q != S_IDLE);

endmodule

FILE: rtl/core/partition_with_target_difference.sv
// ----------------------------------------------------------------------------
// partition_with_target_difference
// Decides whether a list splits into two sets with a given sum difference.
// ----------------------------------------------------------------------------
// Usage: write target_difference through cfg_we_i/cfg_wdata_i while idle.
// Each request (start_i high, busy_o low) loads one element; requests past
// MAX_ELEMS are dropped but a last_element_i mark still closes the list.
// A non-final element is taken while busy_o stays low.
// The final request starts the solve: with W = (MAX_ELEMS*(2^VALUE_WIDTH-1)
// + 64) / 64 memory words per suffix row (64 at default settings) and n
// stored elements, the build sweeps n rows of W words. busy_o stays high
// through the build, the check and, when a split exists, the answer walk.
// The bound is the shift-or sweep, one 64-bit memory word per cycle.
// Results appear on result_valid_o for one cycle each: one per element,
// in input order, or a single result with possible_o low when no split
// exists. last_result_o marks the final one.
// The receiver cannot stall; results are not held.
// Reset clears the element count and target register; the reachability
// memory needs no clearing since each row is rewritten before it is read.
// ----------------------------------------------------------------------------
module partition_with_target_difference #(
  parameter int unsigned MAX_ELEMS   = 16,
  parameter int unsigned VALUE_WIDTH = 8
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  output logic                      busy_o,
  input  logic [pwtd_pkg::EPW-1:0]  element_value_i,
  input  logic                      last_element_i,
  input  logic                      cfg_we_i,
  input  logic [pwtd_pkg::TDW-1:0]  cfg_wdata_i,
  output logic                      result_valid_o,
  output logic                      possible_o,
  output logic [pwtd_pkg::EPW-1:0]  element_out_o,
  output logic                      side_o,
  output logic                      last_result_o
);

  pwtd_pkg::ctrl_cmd_t  cmd;
  pwtd_pkg::dp_status_t status;

  pwtd_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .last_element_i (last_element_i),
    .busy_o         (busy_o),
    .status_i       (status),
    .cmd_o          (cmd)
  );

  pwtd_dp #(
    .MAX_ELEMS   (MAX_ELEMS),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .status_o        (status),
    .element_value_i (element_value_i),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .result_valid_o  (result_valid_o),
    .possible_o      (possible_o),
    .element_out_o   (element_out_o),
    .side_o          (side_o),
    .last_result_o   (last_result_o)
  );

endmodule

FILE: verif/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Loads element lists into partition_with_target_difference, predicts each
// split with a bitset subset-sum solver and checks every result in order.
// ----------------------------------------------------------------------------
module testbench;

  localparam int unsigned EPW  = pwtd_pkg::EPW;
  localparam int unsigned TDW  = pwtd_pkg::TDW;
  localparam int unsigned MAXN = 16;
  localparam int unsigned SUMW = MAXN * 255 + 1;
  localparam int unsigned WDOG = 20000;

  typedef struct packed {
    logic           possible;
    logic [EPW-1:0] elem;
    logic           side;
    logic           last;
  } answer_t;

  logic           clk_i = 1'b0;
  logic           rst_ni = 1'b0;
  logic           start_i = 1'b0;
  logic [EPW-1:0] element_value_i = '0;
  logic           last_element_i = 1'b0;
  logic           cfg_we_i = 1'b0;
  logic [TDW-1:0] cfg_wdata_i = '0;
  logic           busy_o, result_valid_o, possible_o, side_o, last_result_o;
  logic [EPW-1:0] element_out_o;

  partition_with_target_difference dut (.*);

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // predictor state
  logic [TDW-1:0] diff_reg = '0;
  logic [EPW-1:0] list_q[$];
  answer_t        answer_q[$];
  int             mismatches = 0;
  int             quiet_cycles = 0;
  int             send_idle = 0;

  function automatic bit can_end(logic [SUMW-1:0] reach, int rem, int d);
    int k, num;
    k = diff_reg;
    for (int c = 0; c < 2; c++) begin
      num = (c == 0 ? k : -k) - d + rem;
      if (num >= 0 && num % 2 == 0 && num / 2 <= rem && reach[num / 2]) return 1;
    end
    return 0;
  endfunction

  task automatic solve_split();
    logic [SUMW-1:0] reach[MAXN+1];
    int   total[MAXN+1];
    int   n, d;
    answer_t a;
    n = list_q.size();
    reach[n] = 1;
    total[n] = 0;
    for (int i = n - 1; i >= 0; i--) begin
      reach[i] = reach[i+1] | (reach[i+1] << list_q[i]);
      total[i] = total[i+1] + list_q[i];
    end
    if (!can_end(reach[0], total[0], 0)) begin
      a = '{1'b0, '0, 1'b0, 1'b1};
      answer_q = {answer_q, a};
    end else begin
      d = 0;
      for (int i = 0; i < n; i++) begin
        a.possible = 1'b1;
        a.elem = list_q[i];
        a.last = (i == n - 1);
        if (can_end(reach[i+1], total[i+1], d + list_q[i])) begin
          d += list_q[i];
          a.side = 1'b0;
        end else begin
          d -= list_q[i];
          a.side = 1'b1;
        end
        answer_q = {answer_q, a};
      end
    end
    list_q.delete();
  endtask

  // sends one request, predicting at the accepting edge; start_i stays high
  // until the next request or a drain takes it down
  task automatic send_element(logic [EPW-1:0] v, logic lst);
    while ($urandom_range(99) < send_idle) begin
      start_i <= 1'b0;
      @(negedge clk_i);
    end
    start_i <= 1'b1;
    element_value_i <= v;
    last_element_i <= lst;
    do @(posedge clk_i); while (busy_o);
    if (list_q.size() < MAXN) list_q = {list_q, v};
    if (lst) solve_split();
    @(negedge clk_i);
  endtask

  task automatic send_list(int n, int maxv);
    for (int i = 0; i < n; i++)
      send_element(EPW'($urandom_range(maxv)), i == n - 1);
  endtask

  task automatic drain();
    start_i <= 1'b0;
    while (answer_q.size() != 0) @(negedge clk_i);
    repeat (4 * 64 + 20) @(negedge clk_i);
  endtask

  task automatic set_difference(logic [TDW-1:0] v);
    drain();
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    diff_reg = v;
  endtask

  always @(posedge clk_i) begin
    if ((start_i && !busy_o) || result_valid_o) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (result_valid_o) begin
      if (answer_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result at %0t", $time);
      end else if ({possible_o, element_out_o, side_o, last_result_o}
                   !== answer_q[0]) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: expected %p got p=%b e=%0d s=%b l=%b", answer_q[0],
                   possible_o, element_out_o, side_o, last_result_o);
        void'(answer_q.pop_front());
      end else void'(answer_q.pop_front());
    end
    if (quiet_cycles > WDOG) begin
      $display("testbench NOT OK");
      $finish;
    end
  end

  task automatic test_directed();
    set_difference(12'd0);
    send_element(8'd0, 1'b1);
    send_element(8'd255, 1'b1);
    send_list(2, 0);
    send_element(8'd5, 1'b0); send_element(8'd5, 1'b1);
    send_element(8'd3, 1'b0); send_element(8'd4, 1'b1);
    set_difference(12'd1);
    send_element(8'd3, 1'b0); send_element(8'd4, 1'b1);
    set_difference(12'd4080);
    for (int i = 0; i < 16; i++) send_element(8'd255, i == 15);
    set_difference(12'd0);
    // overlong list: extra elements dropped, last mark still closes
    for (int i = 0; i < 19; i++) send_element(8'd170 ^ i[7:0], i == 18);
    send_element(8'd85, 1'b1);
  endtask

  task automatic test_random(int lists);
    for (int l = 0; l < lists; l++) begin
      if (l % 8 == 0) set_difference(TDW'($urandom_range(3) == 0 ?
                                     $urandom_range(4080) : $urandom_range(40)));
      if ($urandom_range(19) == 0) send_list($urandom_range(17, 20), 255);
      else if ($urandom_range(3) == 0) send_list($urandom_range(1, 6), 255);
      else send_list($urandom_range(1, 8), $urandom_range(1, 20));
    end
  endtask

  task automatic test_pause();
    send_list(5, 10);
    drain();
    send_list(4, 10);
  endtask

  initial begin
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    send_idle = 17;
    test_directed();
    test_random(24);
    send_idle = 69;
    test_pause();
    test_random(24);
    send_idle = 0;
    test_random(24);
    drain();
    if (mismatches == 0 && answer_q.size() == 0) $display("testbench OK");
    else $display("testbench NOT OK");
    $finish;
  end
endmodule

FILE: filelist.f
rtl/core/pwtd_pkg.sv
rtl/core/pwtd_dp.sv
rtl/core/pwtd_ctrl.sv
rtl/core/partition_with_target_difference.sv
verif/testbench.sv
